// ===== rtl/core/isu_pkg.sv =====
// Shared types and constants for the Ising Metropolis site update block.
// No dependencies; used by rtl/core/ising_metropolis_site_update.sv.
package isu_pkg;

    // Default lattice side length
    localparam int SIDE_DEF = 64;

    // Fixed request field widths
    localparam int COORD_W = 6;
    localparam int FRAC_W  = 16;
    localparam int DE_W    = 5;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_ACCEPT_DE4 = 1'b0;
    localparam logic REG_ACCEPT_DE8 = 1'b1;

    // Command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TRIAL = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // Flip thresholds
    typedef struct packed {
        logic [FRAC_W-1:0] de4;
        logic [FRAC_W-1:0] de8;
    } t_thresh;

endpackage

// ===== rtl/core/ising_metropolis_site_update.sv =====
// Stage 1 then result register; throughput 1 request per cycle unless the result stalls.
// The rate is set by the three replicated row memories (one read port each, registered
// read data) and a one-entry write bypass that covers the write of the request ahead.
// A stalled result register holds the pipe; the next request is still taken when it drains.
// Reset (synchronous, active low) clears handshake state and both thresholds.
// The lattice itself is not cleared: sites are undefined until loaded.
module ising_metropolis_site_update #(
    parameter int SIDE = isu_pkg::SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [1:0] cmd, [7:2] row, [13:8] col, [14] spin_in, [30:15] rand_frac, [31] zero
    input  logic [31:0]                  s_axis_tdata,
    input  logic                         s_axis_tlast,   // end_of_run
    // Result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] spin_out, [1] flipped, [6:2] delta_energy, [7] zero
    output logic [7:0]                   m_axis_tdata,
    output logic                         m_axis_tlast,   // run_done
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [isu_pkg::PADDR_W-1:0]  paddr,
    input  logic [isu_pkg::PDATA_W-1:0]  pwdata,
    output logic [isu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int AW = (SIDE > 2) ? $clog2(SIDE) : 1;
    localparam int XW = (AW > isu_pkg::COORD_W) ? AW : isu_pkg::COORD_W;
    localparam int FW = isu_pkg::FRAC_W;
    localparam logic [AW-1:0] LAST = AW'(SIDE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    isu_pkg::t_thresh r_thr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == isu_pkg::REG_ACCEPT_DE4) begin
                r_thr.de4 <= pwdata[FW-1:0];
            end else begin
                r_thr.de8 <= pwdata[FW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == isu_pkg::REG_ACCEPT_DE4) begin
            prdata = isu_pkg::PDATA_W'(r_thr.de4);
        end else begin
            prdata = isu_pkg::PDATA_W'(r_thr.de8);
        end
    end

    // ------------------------------------------------------------------
    // Request decode and neighbor addresses
    // ------------------------------------------------------------------
    logic [1:0]          w_cmd_raw;
    logic [XW-1:0]       w_row_x, w_col_x;
    logic [AW-1:0]       w_row, w_col, w_row_n, w_row_s, w_col_w, w_col_e;
    logic                w_inb;
    logic                w_acc, w_adv;

    assign w_cmd_raw = s_axis_tdata[1:0];
    assign w_row_x   = XW'(s_axis_tdata[7:2]);
    assign w_col_x   = XW'(s_axis_tdata[13:8]);
    assign w_row     = w_row_x[AW-1:0];
    assign w_col     = w_col_x[AW-1:0];
    assign w_inb     = (int'(s_axis_tdata[7:2]) < SIDE) && (int'(s_axis_tdata[13:8]) < SIDE);

    // Periodic wrap
    assign w_row_n = (w_row == '0)   ? LAST : w_row - 1'b1;
    assign w_row_s = (w_row == LAST) ? '0   : w_row + 1'b1;
    assign w_col_w = (w_col == '0)   ? LAST : w_col - 1'b1;
    assign w_col_e = (w_col == LAST) ? '0   : w_col + 1'b1;

    // Handshake: stage 1 moves when the result register is free or drained
    logic r_s1_valid, r_out_valid;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic [1:0]    r_s1_cmd;
    logic [AW-1:0] r_s1_row, r_s1_row_n, r_s1_row_s, r_s1_col, r_s1_col_w, r_s1_col_e;
    logic          r_s1_inb, r_s1_spin_in, r_s1_last;
    logic [FW-1:0] r_s1_rand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_cmd     <= w_cmd_raw;
            r_s1_row     <= w_row;
            r_s1_row_n   <= w_row_n;
            r_s1_row_s   <= w_row_s;
            r_s1_col     <= w_col;
            r_s1_col_w   <= w_col_w;
            r_s1_col_e   <= w_col_e;
            r_s1_inb     <= w_inb;
            r_s1_spin_in <= s_axis_tdata[14];
            r_s1_rand    <= s_axis_tdata[30:15];
            r_s1_last    <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Lattice: three identical row memories, one per row read
    // ------------------------------------------------------------------
    logic [SIDE-1:0] mem_n [SIDE];
    logic [SIDE-1:0] mem_c [SIDE];
    logic [SIDE-1:0] mem_s [SIDE];
    logic [SIDE-1:0] r_rd_n, r_rd_c, r_rd_s;

    logic          w_wr_en, w_wr_bit;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_n[r_s1_row][r_s1_col] <= w_wr_bit;
            mem_c[r_s1_row][r_s1_col] <= w_wr_bit;
            mem_s[r_s1_row][r_s1_col] <= w_wr_bit;
        end
        if (w_acc) begin
            r_rd_n <= mem_n[w_row_n];
            r_rd_c <= mem_c[w_row];
            r_rd_s <= mem_s[w_row_s];
        end
    end

    // Last write, patched into read rows that missed it
    logic          r_byp_valid, r_byp_bit;
    logic [AW-1:0] r_byp_row, r_byp_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (w_wr_en) begin
            r_byp_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_byp_row <= r_s1_row;
            r_byp_col <= r_s1_col;
            r_byp_bit <= w_wr_bit;
        end
    end

    logic [SIDE-1:0] w_row_nf, w_row_cf, w_row_sf;

    always_comb begin
        w_row_nf = r_rd_n;
        w_row_cf = r_rd_c;
        w_row_sf = r_rd_s;
        if (r_byp_valid && (r_byp_row == r_s1_row_n)) begin
            w_row_nf[r_byp_col] = r_byp_bit;
        end
        if (r_byp_valid && (r_byp_row == r_s1_row)) begin
            w_row_cf[r_byp_col] = r_byp_bit;
        end
        if (r_byp_valid && (r_byp_row == r_s1_row_s)) begin
            w_row_sf[r_byp_col] = r_byp_bit;
        end
    end

    // ------------------------------------------------------------------
    // Energy change and flip decision
    // ------------------------------------------------------------------
    logic                              w_s;
    logic [2:0]                        w_ups, w_align;
    logic signed [isu_pkg::DE_W-1:0]   w_de;
    logic                              w_accept;

    assign w_s   = w_row_cf[r_s1_col];
    assign w_ups = 3'(w_row_nf[r_s1_col]) + 3'(w_row_sf[r_s1_col])
                 + 3'(w_row_cf[r_s1_col_w]) + 3'(w_row_cf[r_s1_col_e]);
    // Neighbors aligned with the site: dE = 4*align - 8
    assign w_align = w_s ? w_ups : 3'd4 - w_ups;
    assign w_de    = $signed({w_align[2:0], 2'b00}) - 5'sd8;

    always_comb begin
        case (w_align)
            3'd3:    w_accept = r_thr.de4 > r_s1_rand;
            3'd4:    w_accept = r_thr.de8 > r_s1_rand;
            default: w_accept = 1'b1;
        endcase
    end

    // Result fields and lattice write
    logic                            n_spin, n_flip;
    logic signed [isu_pkg::DE_W-1:0] n_de;

    always_comb begin
        n_spin   = 1'b0;
        n_flip   = 1'b0;
        n_de     = '0;
        w_wr_bit = r_s1_spin_in;
        w_wr_en  = 1'b0;
        if (r_s1_inb) begin
            case (isu_pkg::t_cmd'(r_s1_cmd))
                isu_pkg::CMD_LOAD: begin
                    n_spin  = r_s1_spin_in;
                    w_wr_en = 1'b1;
                end
                isu_pkg::CMD_TRIAL: begin
                    n_de     = w_de;
                    n_flip   = w_accept;
                    n_spin   = w_s ^ w_accept;
                    w_wr_bit = ~w_s;
                    w_wr_en  = w_accept;
                end
                isu_pkg::CMD_READ: begin
                    n_spin = w_s;
                end
                default: begin
                    n_spin = 1'b0;
                end
            endcase
        end
        w_wr_en = w_wr_en && r_s1_valid && w_adv;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                            r_spin, r_flip, r_last;
    logic [isu_pkg::DE_W-1:0]        r_de;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_spin <= n_spin;
            r_flip <= n_flip;
            r_de   <= n_de;
            r_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_de, r_flip, r_spin};
    assign m_axis_tlast  = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_de_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_de == 5'b11000 || r_de == 5'b11100 || r_de == 5'b00000
                         || r_de == 5'b00100 || r_de == 5'b01000))
        else $error("delta_energy outside the legal set");

    a_flip_has_de: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_de[4] == 1'b1) |-> r_flip)
        else $error("negative energy change without a flip");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_row) && $stable(r_s1_col)))
        else $error("stage 1 request lost while stalled");

    a_write_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_s1_valid && w_adv && r_s1_inb))
        else $error("lattice written without a request leaving stage 1");

endmodule

// ===== tb/ising_metropolis_site_update_checker.sv =====
// Lattice predictor and result checker for the Ising Metropolis site update block.
// Watches the request, result and APB channels; depends on rtl/core/isu_pkg.sv.
module ising_metropolis_site_update_checker
    import isu_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request stream
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [31:0]        i_req_data,
    input  logic               i_req_last,
    // result stream
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [7:0]         i_res_data,
    input  logic               i_res_last,
    // configuration port
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   spin;
        logic                   flipped;
        logic signed [DE_W-1:0] delta_e;
        logic                   run_done;
    } t_site_result;

    // shadow lattice and thresholds
    bit                lattice [0:SIDE*SIDE-1];
    logic [FRAC_W-1:0] thr_de4;
    logic [FRAC_W-1:0] thr_de8;
    t_site_result      site_results_q [$];

    function automatic int wrap_inc(input int v);
        return (v + 1 >= SIDE) ? 0 : v + 1;
    endfunction

    function automatic int wrap_dec(input int v);
        return (v == 0) ? SIDE - 1 : v - 1;
    endfunction

    // Count one failure; only the first ten get a line of their own
    task automatic flag_miss(input string what, input int expv, input int actv);
        if (o_fail_count < 10)
            $display("%0t checker: %s mismatch, expected %0d, got %0d",
                     $realtime, what, expv, actv);
        o_fail_count++;
    endtask

    // Apply one request to the shadow lattice and queue the result it must produce
    task automatic metropolis_step(input logic [31:0] req, input logic last);
        logic [1:0]        cmd;
        int                r;
        int                c;
        logic              spin_in;
        logic [FRAC_W-1:0] frac;
        t_site_result      res;
        int                s;
        int                ups;
        int                nsum;
        int                de;
        bit                accept;

        cmd     = req[1:0];
        r       = req[7:2];
        c       = req[13:8];
        spin_in = req[14];
        frac    = req[30:15];
        res     = '0;
        res.run_done = last;
        if (r < SIDE && c < SIDE) begin
            case (cmd)
                CMD_LOAD: begin
                    lattice[r*SIDE + c] = spin_in;
                    res.spin = spin_in;
                end
                CMD_READ: begin
                    res.spin = lattice[r*SIDE + c];
                end
                CMD_TRIAL: begin
                    s   = lattice[r*SIDE + c];
                    ups = int'(lattice[wrap_dec(r)*SIDE + c])
                        + int'(lattice[wrap_inc(r)*SIDE + c])
                        + int'(lattice[r*SIDE + wrap_dec(c)])
                        + int'(lattice[r*SIDE + wrap_inc(c)]);
                    nsum = 2*ups - 4;
                    de   = 2 * ((s != 0) ? nsum : -nsum);
                    if (de <= 0)
                        accept = 1'b1;
                    else if (de == 4)
                        accept = thr_de4 > frac;
                    else
                        accept = thr_de8 > frac;
                    if (accept) begin
                        s = 1 - s;
                        lattice[r*SIDE + c] = s[0];
                    end
                    res.spin    = s[0];
                    res.flipped = accept;
                    res.delta_e = de[DE_W-1:0];
                end
                default: ;  // unused command code leaves the lattice alone
            endcase
        end
        site_results_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_site_result want;
        logic [PDATA_W-1:0] reg_val;

        if (!i_rst_n) begin
            site_results_q.delete();
            thr_de4      = '0;
            thr_de8      = '0;
            o_fail_count = 0;
        end else begin
            // result side first: pipeline latency keeps it clear of this edge's request
            if (i_res_valid && i_res_ready) begin
                if (site_results_q.size() == 0) begin
                    flag_miss("unrequested result", 0, i_res_data);
                end else begin
                    want = site_results_q.pop_front();
                    if (i_res_data[0] !== want.spin)
                        flag_miss("spin_out", want.spin, i_res_data[0]);
                    if (i_res_data[1] !== want.flipped)
                        flag_miss("flipped", want.flipped, i_res_data[1]);
                    if (i_res_data[6:2] !== want.delta_e)
                        flag_miss("delta_energy", want.delta_e,
                                  $signed(i_res_data[6:2]));
                    if (i_res_last !== want.run_done)
                        flag_miss("run_done", want.run_done, i_res_last);
                end
            end
            if (i_req_valid && i_req_ready)
                metropolis_step(i_req_data, i_req_last);
            // register port: track writes, check reads
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_ACCEPT_DE8)
                        thr_de8 = i_pwdata[FRAC_W-1:0];
                    else
                        thr_de4 = i_pwdata[FRAC_W-1:0];
                end else begin
                    reg_val = (i_paddr[2] == REG_ACCEPT_DE8) ? PDATA_W'(thr_de8)
                                                             : PDATA_W'(thr_de4);
                    if (i_prdata !== reg_val)
                        flag_miss("register readback", reg_val, i_prdata);
                end
            end
        end
        o_pending = site_results_q.size();
    end

endmodule

// ===== tb/ising_metropolis_site_update_tb.sv =====
// Stimulus and verdict for the Ising Metropolis site update block.
// Depends on rtl/core/isu_pkg.sv, the block itself and tb/ising_metropolis_site_update_checker.sv.
module ising_metropolis_site_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import isu_pkg::*;

    localparam int         LAT          = SIDE_DEF;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 215;
    localparam int         CALM_PHASE   = 3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [7:0]         m_axis_tdata;
    logic               m_axis_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int                 quiet_cycles;
    bit                 calm;
    bit                 site_loaded [0:LAT*LAT-1];
    logic [FRAC_W-1:0]  cur_de4;
    logic [FRAC_W-1:0]  cur_de8;

    ising_metropolis_site_update #(
        .SIDE (LAT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ising_metropolis_site_update_checker #(
        .SIDE (LAT)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 50 MHz clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result-side backpressure, off during the calm phase
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end

    // Watchdog: ends the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ising_metropolis_site_update_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One APB transfer: setup, access until pready, then back to idle
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pack one request, note loaded sites and hand it over on the request stream
    task automatic post_request(input logic [1:0] cmd, input int row, input int col,
                                input logic spin, input logic [FRAC_W-1:0] frac,
                                input logic last);
        bit taken;
        if (cmd == CMD_LOAD)
            site_loaded[row*LAT + col] = 1'b1;
        while (!calm && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, frac, spin, col[COORD_W-1:0], row[COORD_W-1:0], cmd};
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Random request biased toward the wrapped corner; a trial or read that would
    // touch an unloaded site turns into a load of that site
    task automatic random_request();
        int                sel;
        int                r;
        int                c;
        int                k;
        int                nr [5];
        int                nc [5];
        int                span;
        logic [1:0]        cmd;
        logic [FRAC_W-1:0] frac;

        sel = $urandom_range(99);
        cmd = (sel < 15) ? CMD_LOAD : (sel < 80) ? CMD_TRIAL :
              (sel < 94) ? CMD_READ : CMD_UNUSED;
        if ($urandom_range(99) < 70) begin
            r = (LAT - 2 + $urandom_range(4)) % LAT;
            c = (LAT - 2 + $urandom_range(4)) % LAT;
        end else begin
            r = $urandom_range(LAT - 1);
            c = $urandom_range(LAT - 1);
        end
        nr[0] = r;                 nc[0] = c;
        nr[1] = (r + LAT - 1) % LAT; nc[1] = c;
        nr[2] = (r + 1) % LAT;     nc[2] = c;
        nr[3] = r;                 nc[3] = (c + LAT - 1) % LAT;
        nr[4] = r;                 nc[4] = (c + 1) % LAT;
        span = (cmd == CMD_TRIAL) ? 5 : (cmd == CMD_READ) ? 1 : 0;
        for (k = 0; k < span; k++) begin
            if (!site_loaded[nr[k]*LAT + nc[k]]) begin
                cmd = CMD_LOAD;
                r   = nr[k];
                c   = nc[k];
                break;
            end
        end
        // fractions near the thresholds hit both sides of the compare
        sel = $urandom_range(99);
        if (sel < 10)      frac = cur_de4;
        else if (sel < 20) frac = cur_de8;
        else if (sel < 25) frac = cur_de4 - 1'b1;
        else if (sel < 30) frac = cur_de8 - 1'b1;
        else if (sel < 34) frac = '0;
        else if (sel < 38) frac = '1;
        else               frac = FRAC_W'($urandom_range(16'hFFFF));
        post_request(cmd, r, c, 1'($urandom_range(1)), frac, $urandom_range(99) < 5);
    endtask

    initial begin
        logic [FRAC_W-1:0] phase_de4 [PHASES];
        logic [FRAC_W-1:0] phase_de8 [PHASES];
        int                p;
        int                n;

        phase_de4 = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000};
        phase_de8 = '{16'hFFFF, 16'h0000, 16'h2000, 16'hFFFF, 16'h0000, 16'h0000};
        phase_de4[PHASES-1] = FRAC_W'($urandom_range(16'hFFFF));
        phase_de8[PHASES-1] = FRAC_W'($urandom_range(16'hFFFF));

        calm          = 1'b0;
        cur_de4       = '0;
        cur_de8       = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: site (0,0) with all-up neighbors, then walk dE through
        // 8, 4, 0, -4, -8 with the reset thresholds (no uphill flips)
        post_request(CMD_LOAD,  0,  0, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  63, 0, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  1,  0, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  0, 63, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  0,  1, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_TRIAL, 0,  0, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_READ,  0,  0, 1'b0, 16'h0000, 1'b1);
        post_request(CMD_LOAD,  0,  1, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_TRIAL, 0,  0, 1'b0, 16'hFFFF, 1'b0);
        post_request(CMD_LOAD,  1,  0, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_TRIAL, 0,  0, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  0,  0, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  63, 0, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_TRIAL, 0,  0, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  0,  0, 1'b1, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  0, 63, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_TRIAL, 0,  0, 1'b0, 16'h0000, 1'b0);
        // spin now down with all neighbors down: uphill by 8, never taken here
        post_request(CMD_TRIAL, 0,  0, 1'b1, 16'hFFFF, 1'b0);
        // unused command with every field bit high
        post_request(CMD_UNUSED, 63, 63, 1'b1, 16'hFFFF, 1'b1);
        post_request(CMD_READ,  63, 0, 1'b0, 16'h0000, 1'b0);
        post_request(CMD_LOAD,  63, 63, 1'b1, 16'hFFFF, 1'b1);
        post_request(CMD_TRIAL, 0,  0, 1'b1, 16'h0001, 1'b1);

        // Random phases, each under its own pair of thresholds
        for (p = 0; p < PHASES; p++) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while (pending != 0);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            cur_de4 = phase_de4[p];
            cur_de8 = phase_de8[p];
            apb_access(1'b1, {REG_ACCEPT_DE4, 2'b00}, PDATA_W'(cur_de4));
            apb_access(1'b0, {REG_ACCEPT_DE4, 2'b00}, '0);
            apb_access(1'b1, {REG_ACCEPT_DE8, 2'b00}, PDATA_W'(cur_de8));
            apb_access(1'b0, {REG_ACCEPT_DE8, 2'b00}, '0);
            calm = (p == CALM_PHASE);
            for (n = 0; n < PHASE_ITEMS; n++)
                random_request();
            calm = 1'b0;
        end

        // Drain and give the verdict
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ising_metropolis_site_update_tb: clean");
        else
            $display("ising_metropolis_site_update_tb: errors");
        $finish;
    end

endmodule
